>>> sv/infix_to_postfix_converter_defines.svh
// Assertion macros shared by the infix to postfix converter RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef INFIX_TO_POSTFIX_CONVERTER_DEFINES_SVH
`define INFIX_TO_POSTFIX_CONVERTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define ITP_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ITP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/itp_pkg.sv
// Shared types, constants and character helpers of the infix to postfix converter.
// No dependencies; used by the controller, the datapath and the top level.
package itp_pkg;

   localparam int STACK_DEPTH = 32;
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W      = $clog2(STACK_DEPTH);

   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_CARET  = 8'h5E;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_0      = 8'h30;
   localparam logic [7:0] CH_9      = 8'h39;
   localparam logic [7:0] CH_UA     = 8'h41;
   localparam logic [7:0] CH_UZ     = 8'h5A;
   localparam logic [7:0] CH_LA     = 8'h61;
   localparam logic [7:0] CH_LZ     = 8'h7A;

   localparam logic [1:0] PREC_POW  = 2'd3;
   localparam logic [1:0] PREC_MUL  = 2'd2;
   localparam logic [1:0] PREC_ADD  = 2'd1;
   localparam logic [1:0] PREC_NONE = 2'd0;

   typedef enum logic [2:0] {
      CLS_NUL,
      CLS_ALNUM,
      CLS_LPAREN,
      CLS_RPAREN,
      CLS_OP
   } cls_type;

   typedef struct packed {
      logic accept;
      logic push;
      logic pop_emit;
      logic pop_drop;
      logic emit_sym;
      logic emit_term;
      logic set_under;
      logic finish;
   } cmd_type;

   typedef struct packed {
      cls_type cls;
      logic    end_of_expr;
      logic    top_ready;
      logic    count_zero;
      logic    top_is_lparen;
      logic    top_prec_ge;
      logic    emit_ok;
      logic    stg_valid;
   } sts_type;

   function automatic logic [1:0] prec_of(input logic [7:0] c);
      case (c) inside
         CH_CARET:           return PREC_POW;
         CH_STAR, CH_SLASH:  return PREC_MUL;
         CH_PLUS, CH_MINUS:  return PREC_ADD;
         default:            return PREC_NONE;
      endcase
   endfunction

   function automatic cls_type classify(input logic [7:0] c);
      unique case (c) inside
         CH_NUL:                                   return CLS_NUL;
         [CH_0:CH_9], [CH_UA:CH_UZ], [CH_LA:CH_LZ]: return CLS_ALNUM;
         CH_LPAREN:                                return CLS_LPAREN;
         CH_RPAREN:                                return CLS_RPAREN;
         default:                                  return CLS_OP;
      endcase
   endfunction

endpackage

>>> sv/itp_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module itp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/itp_datapath.sv
// Datapath of the converter: operator stack (top register plus RAM), result staging
// and output register. Depends on itp_pkg, itp_ram and the assertion macro header.
`include "infix_to_postfix_converter_defines.svh"

module itp_datapath (
   input  logic              clock,
   input  logic              reset,
   input  itp_pkg::cmd_type  cmd,
   output itp_pkg::sts_type  sts,
   input  logic [7:0]        req_symbol,
   input  logic              req_end_of_expr,
   input  logic              rsp_stall,
   output logic              rsp_valid,
   output logic [7:0]        rsp_out_symbol,
   output logic              rsp_last_of_run,
   output logic              rsp_terminator,
   output logic [1:0]        rsp_error_flags
);

   logic [7:0]               sym_ff, sym_in;
   logic                     end_ff, end_in;
   logic [7:0]               top_ff, top_in;
   logic [itp_pkg::CNT_W-1:0] count_ff, count_in;
   logic                     reload_ff, reload_in;
   logic [1:0]               sticky_ff, sticky_in;

   logic                     stg_valid_ff, stg_valid_in;
   logic [7:0]               stg_sym_ff, stg_sym_in;
   logic                     stg_term_ff, stg_term_in;
   logic [1:0]               stg_err_ff, stg_err_in;

   logic                     out_valid_ff, out_valid_in;
   logic [7:0]               out_sym_ff, out_sym_in;
   logic                     out_last_ff, out_last_in;
   logic                     out_term_ff, out_term_in;
   logic [1:0]               out_err_ff, out_err_in;

   logic                     ram_we, ram_re;
   logic [itp_pkg::ADDR_W-1:0] ram_waddr, ram_raddr;
   logic [7:0]               ram_rd_data;

   logic [itp_pkg::CNT_W-1:0] cnt_m1, cnt_m2;
   logic                     count_zero, count_full, count_ge2;
   logic                     out_free, emit_any;
   logic [7:0]               emit_sym;
   logic [1:0]               emit_err;

   assign cnt_m1     = count_ff - itp_pkg::CNT_W'(1);
   assign cnt_m2     = count_ff - itp_pkg::CNT_W'(2);
   assign count_zero = (count_ff == '0);
   assign count_full = (count_ff == itp_pkg::CNT_W'(itp_pkg::STACK_DEPTH));
   assign count_ge2  = (count_ff >= itp_pkg::CNT_W'(2));
   assign out_free   = !out_valid_ff || !rsp_stall;
   assign emit_any   = cmd.emit_sym || cmd.pop_emit || cmd.emit_term;
   assign emit_sym   = cmd.emit_sym ? sym_ff : (cmd.pop_emit ? top_ff : itp_pkg::CH_NUL);
   assign emit_err   = cmd.emit_term ? sticky_ff : 2'b00;

   // The top of stack lives in top_ff; the entries below it are in the RAM.
   itp_ram #(
      .WIDTH (8),
      .DEPTH (itp_pkg::STACK_DEPTH)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (top_ff),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      sym_in       = sym_ff;
      end_in       = end_ff;
      top_in       = top_ff;
      count_in     = count_ff;
      reload_in    = 1'b0;
      sticky_in    = sticky_ff;
      stg_valid_in = stg_valid_ff;
      stg_sym_in   = stg_sym_ff;
      stg_term_in  = stg_term_ff;
      stg_err_in   = stg_err_ff;
      out_valid_in = out_valid_ff;
      out_sym_in   = out_sym_ff;
      out_last_in  = out_last_ff;
      out_term_in  = out_term_ff;
      out_err_in   = out_err_ff;
      ram_we       = 1'b0;
      ram_re       = 1'b0;
      ram_waddr    = cnt_m1[itp_pkg::ADDR_W-1:0];
      ram_raddr    = cnt_m2[itp_pkg::ADDR_W-1:0];

      if (cmd.accept) begin
         sym_in = req_symbol;
         end_in = req_end_of_expr;
      end

      if (reload_ff) begin
         top_in = ram_rd_data;
      end

      if (cmd.push) begin
         if (count_full) begin
            sticky_in[0] = 1'b1;
         end else begin
            ram_we   = !count_zero;
            top_in   = sym_ff;
            count_in = count_ff + itp_pkg::CNT_W'(1);
         end
      end

      if (cmd.pop_emit || cmd.pop_drop) begin
         count_in  = cnt_m1;
         ram_re    = count_ge2;
         reload_in = count_ge2;
      end

      if (cmd.set_under) begin
         sticky_in[1] = 1'b1;
      end
      if (cmd.emit_term) begin
         sticky_in = 2'b00;
      end

      if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end

      // A staged result moves on once the next one exists or the item ends,
      // which is when its last_of_run value is known.
      if (emit_any) begin
         if (stg_valid_ff) begin
            out_valid_in = 1'b1;
            out_sym_in   = stg_sym_ff;
            out_last_in  = 1'b0;
            out_term_in  = stg_term_ff;
            out_err_in   = stg_err_ff;
         end
         stg_valid_in = 1'b1;
         stg_sym_in   = emit_sym;
         stg_term_in  = cmd.emit_term;
         stg_err_in   = emit_err;
      end

      if (cmd.finish && stg_valid_ff) begin
         out_valid_in = 1'b1;
         out_sym_in   = stg_sym_ff;
         out_last_in  = 1'b1;
         out_term_in  = stg_term_ff;
         out_err_in   = stg_err_ff;
         stg_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         reload_ff    <= 1'b0;
         sticky_ff    <= 2'b00;
         stg_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         reload_ff    <= reload_in;
         sticky_ff    <= sticky_in;
         stg_valid_ff <= stg_valid_in;
         out_valid_ff <= out_valid_in;
      end
      sym_ff      <= sym_in;
      end_ff      <= end_in;
      top_ff      <= top_in;
      stg_sym_ff  <= stg_sym_in;
      stg_term_ff <= stg_term_in;
      stg_err_ff  <= stg_err_in;
      out_sym_ff  <= out_sym_in;
      out_last_ff <= out_last_in;
      out_term_ff <= out_term_in;
      out_err_ff  <= out_err_in;
   end

   assign sts.cls           = itp_pkg::classify(sym_ff);
   assign sts.end_of_expr   = end_ff;
   assign sts.top_ready     = !reload_ff;
   assign sts.count_zero    = count_zero;
   assign sts.top_is_lparen = (top_ff == itp_pkg::CH_LPAREN);
   assign sts.top_prec_ge   = (itp_pkg::prec_of(top_ff) >= itp_pkg::prec_of(sym_ff));
   assign sts.emit_ok       = !stg_valid_ff || out_free;
   assign sts.stg_valid     = stg_valid_ff;

   assign rsp_valid       = out_valid_ff;
   assign rsp_out_symbol  = out_sym_ff;
   assign rsp_last_of_run = out_last_ff;
   assign rsp_terminator  = out_term_ff;
   assign rsp_error_flags = out_err_ff;

   `ITP_ASSERT_IMPLIES(a_no_pop_on_stale_top, clock, reset,
      cmd.pop_emit || cmd.pop_drop || cmd.push, !reload_ff && !(cmd.pop_emit && count_zero),
      "stack touched while the top register is being refilled or the stack is empty")
   `ITP_ASSERT_IMPLIES(a_no_result_overwrite, clock, reset,
      emit_any && stg_valid_ff, out_free,
      "staged result moved into an output register that still holds a result")
   `ITP_ASSERT_NEXT(a_sticky_cleared, clock, reset,
      cmd.emit_term, sticky_ff == 2'b00,
      "error flags not cleared after the terminator")

endmodule

>>> sv/itp_ctrl.sv
// Controller state machine of the converter: sequences push, pop, flush and finish.
// Depends on itp_pkg and the assertion macro header.
`include "infix_to_postfix_converter_defines.svh"

module itp_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  itp_pkg::sts_type sts,
   output itp_pkg::cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLASSIFY,
      ST_CLOSE,
      ST_OPLOOP,
      ST_ENDCHK,
      ST_FLUSH,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_CLASSIFY;
            end
         end
         ST_CLASSIFY: begin
            if (sts.top_ready) begin
               unique case (sts.cls)
                  itp_pkg::CLS_NUL: begin
                     state_in = ST_ENDCHK;
                  end
                  itp_pkg::CLS_ALNUM: begin
                     if (sts.emit_ok) begin
                        cmd.emit_sym = 1'b1;
                        state_in     = ST_ENDCHK;
                     end
                  end
                  itp_pkg::CLS_LPAREN: begin
                     cmd.push = 1'b1;
                     state_in = ST_ENDCHK;
                  end
                  itp_pkg::CLS_RPAREN: begin
                     state_in = ST_CLOSE;
                  end
                  default: begin
                     state_in = ST_OPLOOP;
                  end
               endcase
            end
         end
         ST_CLOSE: begin
            if (sts.top_ready) begin
               if (sts.count_zero) begin
                  cmd.set_under = 1'b1;
                  state_in      = ST_ENDCHK;
               end else if (sts.top_is_lparen) begin
                  cmd.pop_drop = 1'b1;
                  state_in     = ST_ENDCHK;
               end else if (sts.emit_ok) begin
                  cmd.pop_emit = 1'b1;
               end
            end
         end
         ST_OPLOOP: begin
            if (sts.top_ready) begin
               if (!sts.count_zero && !sts.top_is_lparen && sts.top_prec_ge) begin
                  cmd.pop_emit = sts.emit_ok;
               end else begin
                  cmd.push = 1'b1;
                  state_in = ST_ENDCHK;
               end
            end
         end
         ST_ENDCHK: begin
            state_in = sts.end_of_expr ? ST_FLUSH : ST_FINISH;
         end
         ST_FLUSH: begin
            if (sts.top_ready && sts.emit_ok) begin
               if (!sts.count_zero) begin
                  cmd.pop_emit = 1'b1;
               end else begin
                  cmd.emit_term = 1'b1;
                  state_in      = ST_FINISH;
               end
            end
         end
         ST_FINISH: begin
            if (sts.emit_ok) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

   `ITP_ASSERT_IMPLIES(a_idle_means_drained, clock, reset,
      state_ff == ST_IDLE, !sts.stg_valid,
      "a result is still staged while the controller waits for a new item")

endmodule

>>> sv/infix_to_postfix_converter.sv
// Top level of the infix to postfix converter: controller plus datapath.
// Depends on itp_pkg, itp_ctrl, itp_datapath (and through it itp_ram).
//
//   Channel  Direction  Handshake             Payload
//   req      in         req_valid/req_stall   req_symbol[7:0], req_end_of_expr
//   rsp      out        rsp_valid/rsp_stall   rsp_out_symbol[7:0], rsp_last_of_run,
//                                             rsp_terminator, rsp_error_flags[1:0]
//
// Each item is taken, classified and checked for the end of expression. An operator or a
// closing bracket first pops what it must; after a pop that leaves the stack non-empty, the
// RAM read refills the top register. An end-of-expression item also emits the terminator.
// Reset is synchronous and active high; it empties the stack and clears the error flags,
// and items are taken right after reset since the stack RAM needs no clearing pass.
// A stall on rsp holds the result in the output register and pauses the item in progress.
//
// The block works on one item at a time. The controller walks the shunting-yard steps
// (classify, pop loop, push, flush) and the datapath holds the stack and the results.
// Each result first sits in a staging register until the next one is produced or the
// item ends, so that the last_of_run flag can be attached before the transfer is offered.
module infix_to_postfix_converter (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_symbol,
   input  logic       req_end_of_expr,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_symbol,
   output logic       rsp_last_of_run,
   output logic       rsp_terminator,
   output logic [1:0] rsp_error_flags
);

   // Commands flow from the controller to the datapath, status flows back.
   itp_pkg::cmd_type cmd;
   itp_pkg::sts_type sts;

   itp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   itp_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_symbol      (req_symbol),
      .req_end_of_expr (req_end_of_expr),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_out_symbol  (rsp_out_symbol),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_terminator  (rsp_terminator),
      .rsp_error_flags (rsp_error_flags)
   );

endmodule

>>> dv/tb_infix_to_postfix_converter.sv
// Self-checking testbench for the infix to postfix converter: directed rows, then random
// expressions, checked against an operator-stack predictor. Depends on itp_pkg and the RTL.
module tb_infix_to_postfix_converter;

   timeunit 1ns;
   timeprecision 1ps;

   // Error flag codes carried by the terminator.
   localparam logic [1:0] ERR_NONE      = 2'b00;
   localparam logic [1:0] ERR_OVERFLOW  = 2'b01;
   localparam logic [1:0] ERR_UNDERFLOW = 2'b10;

   localparam int RANDOM_ITEMS  = 230;
   localparam int IDLE_PERCENT  = 19;
   localparam int SEND_QUIET_LO = 60;     // Sender runs without gaps for these items.
   localparam int SEND_QUIET_HI = 120;
   localparam int RECV_QUIET_LO = 250;    // Receiver never stalls for these transfers.
   localparam int RECV_QUIET_HI = 330;
   localparam int HOLD_AT       = 150;    // Transfer count that starts the long hold-off.
   localparam int HOLD_CYCLES   = 400;
   localparam int DRAIN_CYCLES  = 100;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int MAX_REPORTS   = 10;

   // One postfix character as it leaves the block.
   typedef struct packed {
      logic [7:0] sym;
      logic       last;
      logic       term;
      logic [1:0] err;
   } postfix_type;

   // One infix character as it enters the block.
   typedef struct packed {
      logic [7:0] sym;
      logic       eoe;
   } infix_type;

   // A directed row; when typed is set, the n results r0, r1 are the expectation.
   typedef struct packed {
      logic [7:0]  sym;
      logic        eoe;
      logic        typed;
      logic [1:0]  n;
      postfix_type r0;
      postfix_type r1;
   } directed_row_type;

   localparam postfix_type NO_RESULT = '{8'h00, 1'b0, 1'b0, ERR_NONE};

   // The first five rows are typed in. Row one follows reset and must come straight through.
   // Row two is a closing bracket with nothing to match, so the terminator reports underflow.
   // Row three is the all-ones byte, which is pushed as an operator and flushed right away.
   // Rows four and five check that a NUL is ignored and that a NUL still triggers the flush.
   // The rest walks every operator, left-associative '^', nested brackets, an unmatched
   // opening bracket at the end and an operand that carries the end flag.
   localparam int NUM_DIRECTED = 25;
   localparam directed_row_type DIRECTED [NUM_DIRECTED] = '{
      '{"a",     1'b0, 1'b1, 2'd1, '{"a", 1'b1, 1'b0, ERR_NONE}, NO_RESULT},
      '{")",     1'b1, 1'b1, 2'd1, '{8'h00, 1'b1, 1'b1, ERR_UNDERFLOW}, NO_RESULT},
      '{8'hFF,   1'b1, 1'b1, 2'd2, '{8'hFF, 1'b0, 1'b0, ERR_NONE},
                                  '{8'h00, 1'b1, 1'b1, ERR_NONE}},
      '{8'h00,   1'b0, 1'b1, 2'd0, NO_RESULT, NO_RESULT},
      '{8'h00,   1'b1, 1'b1, 2'd1, '{8'h00, 1'b1, 1'b1, ERR_NONE}, NO_RESULT},
      '{"0",     1'b0, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
      '{"+",     1'b0, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
      '{"9",     1'b0, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
      '{"*",     1'b0, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
      '{"Z",     1'b0, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
      '{"^",     1'b0, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
      '{"z",     1'b0, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
      '{"^",     1'b0, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
      '{"A",     1'b0, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
      '{"-",     1'b0, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
      '{"(",     1'b0, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
      '{"b",     1'b0, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
      '{"/",     1'b0, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
      '{"(",     1'b0, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
      '{"y",     1'b0, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
      '{")",     1'b0, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
      '{")",     1'b0, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
      '{"(",     1'b1, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
      '{"~",     1'b1, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
      '{"1",     1'b1, 1'b0, 2'd0, NO_RESULT, NO_RESULT}
   };

   logic       clock;
   logic       reset           = 1'b1;
   logic       req_valid       = 1'b0;
   logic       req_stall;
   logic [7:0] req_symbol      = 8'h00;
   logic       req_end_of_expr = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall       = 1'b0;
   logic [7:0] rsp_out_symbol;
   logic       rsp_last_of_run;
   logic       rsp_terminator;
   logic [1:0] rsp_error_flags;

   infix_to_postfix_converter uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_symbol      (req_symbol),
      .req_end_of_expr (req_end_of_expr),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_symbol  (rsp_out_symbol),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_terminator  (rsp_terminator),
      .rsp_error_flags (rsp_error_flags)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------------------------------
   // Predictor. It keeps its own operator stack, fill level and sticky error flags, and for
   // every accepted character appends the postfix characters it causes to postfix_run.
   // ---------------------------------------------------------------------------------------
   logic [7:0]  op_stack [itp_pkg::STACK_DEPTH];
   int unsigned op_depth     = 0;
   logic [1:0]  sticky_flags = ERR_NONE;
   postfix_type postfix_run [$];

   // Postfix characters still owed by the block, oldest first.
   postfix_type pending_postfix [$];

   int          fail_count  = 0;
   int          items_sent  = 0;
   bit          sender_quiet = 1'b0;
   infix_type   stim_q [$];

   function automatic int unsigned rank_of(input logic [7:0] c);
      if (c == itp_pkg::CH_CARET) return 3;
      if (c == itp_pkg::CH_STAR || c == itp_pkg::CH_SLASH) return 2;
      if (c == itp_pkg::CH_PLUS || c == itp_pkg::CH_MINUS) return 1;
      return 0;
   endfunction

   function automatic bit is_operand(input logic [7:0] c);
      return (c >= itp_pkg::CH_0 && c <= itp_pkg::CH_9) ||
             (c >= itp_pkg::CH_UA && c <= itp_pkg::CH_UZ) ||
             (c >= itp_pkg::CH_LA && c <= itp_pkg::CH_LZ);
   endfunction

   function automatic void emit_char(input logic [7:0] c, input logic term,
                                     input logic [1:0] err);
      postfix_run.push_back('{c, 1'b0, term, err});
   endfunction

   function automatic void pop_to_output();
      op_depth = op_depth - 1;
      emit_char(op_stack[op_depth], 1'b0, ERR_NONE);
   endfunction

   // A push onto a full stack is dropped and remembered as overflow.
   function automatic void push_operator(input logic [7:0] c);
      if (op_depth >= itp_pkg::STACK_DEPTH) begin
         sticky_flags = sticky_flags | ERR_OVERFLOW;
      end else begin
         op_stack[op_depth] = c;
         op_depth = op_depth + 1;
      end
   endfunction

   function automatic void convert_symbol(input logic [7:0] c, input logic eoe);
      int unsigned rank;
      postfix_run.delete();
      if (c == itp_pkg::CH_NUL) begin
         // A NUL does nothing by itself.
      end else if (is_operand(c)) begin
         emit_char(c, 1'b0, ERR_NONE);
      end else if (c == itp_pkg::CH_LPAREN) begin
         push_operator(c);
      end else if (c == itp_pkg::CH_RPAREN) begin
         while (op_depth != 0 && op_stack[op_depth - 1] != itp_pkg::CH_LPAREN)
            pop_to_output();
         // A closing bracket without its partner underflows the stack.
         if (op_depth == 0) sticky_flags = sticky_flags | ERR_UNDERFLOW;
         else op_depth = op_depth - 1;
      end else begin
         rank = rank_of(c);
         while (op_depth != 0 && op_stack[op_depth - 1] != itp_pkg::CH_LPAREN &&
                rank_of(op_stack[op_depth - 1]) >= rank) pop_to_output();
         push_operator(c);
      end
      if (eoe) begin
         // Whatever is left, unmatched brackets included, goes out before the terminator.
         while (op_depth != 0) pop_to_output();
         emit_char(itp_pkg::CH_NUL, 1'b1, sticky_flags);
         sticky_flags = ERR_NONE;
      end
      if (postfix_run.size() != 0) postfix_run[postfix_run.size() - 1].last = 1'b1;
   endfunction

   task automatic note_failure(input string what);
      fail_count++;
      if (fail_count <= MAX_REPORTS) $display("mismatch: %s", what);
   endtask

   // ---------------------------------------------------------------------------------------
   // Sender. Offers one character, idling at random first unless a quiet stretch is on, and
   // returns at the edge of the transfer. Valid stays high afterwards, so a following call
   // only changes the payload, and the payload is never touched while it is stalled.
   // ---------------------------------------------------------------------------------------
   task automatic offer_symbol(input logic [7:0] c, input logic eoe);
      if (!sender_quiet) begin
         while ($urandom_range(99) < IDLE_PERCENT) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid       <= 1'b1;
      req_symbol      <= c;
      req_end_of_expr <= eoe;
      do @(posedge clock); while (req_stall);
   endtask

   // ---------------------------------------------------------------------------------------
   // Random stimulus builders. Each one fills stim_q with one expression (noise may hold several)
   // whose last character carries the end flag.
   // ---------------------------------------------------------------------------------------
   function automatic logic [7:0] random_operand();
      case ($urandom_range(2))
         0:       return itp_pkg::CH_0 + 8'($urandom_range(9));
         1:       return itp_pkg::CH_UA + 8'($urandom_range(25));
         default: return itp_pkg::CH_LA + 8'($urandom_range(25));
      endcase
   endfunction

   function automatic logic [7:0] random_operator();
      int unsigned pick;
      pick = $urandom_range(19);
      if (pick < 4)  return itp_pkg::CH_CARET;
      if (pick < 7)  return itp_pkg::CH_STAR;
      if (pick < 9)  return itp_pkg::CH_SLASH;
      if (pick < 13) return itp_pkg::CH_PLUS;
      if (pick < 17) return itp_pkg::CH_MINUS;
      if (pick < 18) return "~";
      return 8'($urandom_range(255, 128));
   endfunction

   function automatic void add_char(input logic [7:0] c);
      stim_q.push_back('{c, 1'b0});
   endfunction

   // Clears every end flag and puts one on the last character.
   function automatic void close_expression();
      foreach (stim_q[i]) stim_q[i].eoe = 1'b0;
      stim_q[stim_q.size() - 1].eoe = 1'b1;
   endfunction

   function automatic void build_well_formed();
      int unsigned open_count;
      int unsigned operands;
      open_count = 0;
      operands   = $urandom_range(8, 1);
      for (int unsigned t = 0; t < operands; t++) begin
         while ($urandom_range(3) == 0 && open_count < 6) begin
            add_char(itp_pkg::CH_LPAREN);
            open_count++;
         end
         add_char(random_operand());
         // An occasional NUL in the middle must leave the expression untouched.
         if ($urandom_range(15) == 0) add_char(itp_pkg::CH_NUL);
         while (open_count > 0 && $urandom_range(2) == 0) begin
            add_char(itp_pkg::CH_RPAREN);
            open_count--;
         end
         if (t != operands - 1) add_char(random_operator());
      end
      while (open_count > 0) begin
         add_char(itp_pkg::CH_RPAREN);
         open_count--;
      end
      if ($urandom_range(9) == 0) add_char(itp_pkg::CH_NUL);
      close_expression();
   endfunction

   // A well-formed expression with one character replaced or dropped.
   function automatic void build_broken();
      int unsigned spot;
      build_well_formed();
      spot = $urandom_range(stim_q.size() - 1);
      case ($urandom_range(3))
         0:       stim_q[spot].sym = itp_pkg::CH_RPAREN;
         1:       stim_q[spot].sym = itp_pkg::CH_LPAREN;
         2:       stim_q[spot].sym = 8'($urandom_range(255));
         default: if (stim_q.size() > 1) stim_q.delete(spot);
      endcase
      close_expression();
   endfunction

   // Mostly opening brackets, often enough to fill the 32-entry stack and overflow it, then a full flush.
   function automatic void build_deep_nest();
      int unsigned length;
      length = $urandom_range(38, 28);
      for (int unsigned i = 0; i < length; i++) begin
         add_char(($urandom_range(9) == 0) ? random_operand() : itp_pkg::CH_LPAREN);
      end
      add_char(random_operand());
      close_expression();
   endfunction

   function automatic void build_noise();
      int unsigned length;
      length = $urandom_range(12, 3);
      for (int unsigned i = 0; i < length; i++) begin
         stim_q.push_back('{8'($urandom_range(255)), 1'($urandom_range(9) == 0)});
      end
      stim_q[stim_q.size() - 1].eoe = 1'b1;
   endfunction

   // ---------------------------------------------------------------------------------------
   // Receiver. Checks every result transfer against the oldest expectation, then decides the
   // stall for the next cycle. Once, after HOLD_AT transfers, it holds off for the stretch set by
   // HOLD_CYCLES while the sender keeps offering, so that the block backs up and stalls req.
   // ---------------------------------------------------------------------------------------
   int unsigned rsp_count = 0;
   int unsigned hold_left = 0;
   bit          hold_done = 1'b0;

   always @(posedge clock) begin
      postfix_type got;
      postfix_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_out_symbol, rsp_last_of_run, rsp_terminator, rsp_error_flags};
            if (pending_postfix.size() == 0) begin
               note_failure($sformatf("unexpected result sym=%h last=%b term=%b err=%b",
                                      got.sym, got.last, got.term, got.err));
            end else begin
               want = pending_postfix.pop_front();
               if (got.sym !== want.sym || got.last !== want.last ||
                   got.term !== want.term || got.err !== want.err) begin
                  note_failure($sformatf(
                     {"result %0d: expected sym=%h last=%b term=%b err=%b, ",
                      "got sym=%h last=%b term=%b err=%b"},
                     rsp_count, want.sym, want.last, want.term, want.err,
                     got.sym, got.last, got.term, got.err));
               end
            end
            rsp_count++;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (!hold_done && rsp_count >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            rsp_stall <= 1'b1;
         end else if (rsp_count >= RECV_QUIET_LO && rsp_count < RECV_QUIET_HI) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(99) < IDLE_PERCENT);
         end
      end
   end

   // Hard limit on the run; a hung handshake ends here.
   int unsigned cycle_count = 0;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Main sequence: reset, directed rows, random expressions, drain and verdict.
   // ---------------------------------------------------------------------------------------
   initial begin
      directed_row_type row;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < NUM_DIRECTED; i++) begin
         row = DIRECTED[i];
         offer_symbol(row.sym, row.eoe);
         // The predictor runs on typed rows too, so that its stack stays in step.
         convert_symbol(row.sym, row.eoe);
         if (row.typed) begin
            if (row.n >= 1) pending_postfix.push_back(row.r0);
            if (row.n >= 2) pending_postfix.push_back(row.r1);
         end else begin
            foreach (postfix_run[k]) pending_postfix.push_back(postfix_run[k]);
         end
      end

      // Mostly well-formed expressions with random content, the rest broken, deep nests or noise.
      while (items_sent < RANDOM_ITEMS) begin
         stim_q.delete();
         case ($urandom_range(99)) inside
            [0:59]:  build_well_formed();
            [60:71]: build_broken();
            [72:79]: build_deep_nest();
            default: build_noise();
         endcase
         foreach (stim_q[k]) begin
            sender_quiet = (items_sent >= SEND_QUIET_LO && items_sent < SEND_QUIET_HI);
            offer_symbol(stim_q[k].sym, stim_q[k].eoe);
            convert_symbol(stim_q[k].sym, stim_q[k].eoe);
            foreach (postfix_run[j]) pending_postfix.push_back(postfix_run[j]);
            if (stim_q[k].sym != itp_pkg::CH_NUL || stim_q[k].eoe) items_sent++;
         end
      end
      req_valid <= 1'b0;

      while (pending_postfix.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_postfix.size() != 0) begin
         note_failure($sformatf("%0d results never arrived", pending_postfix.size()));
      end

      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
